// ===== rtl/fmpll_pkg.sv =====
`timescale 1ns / 1ps

package fmpll_pkg;

   // Request codes carried on the action field.
   typedef enum logic [1:0] {
      ACT_SET_FREQ   = 2'd0,
      ACT_SET_POWER  = 2'd1,
      ACT_SET_STEREO = 2'd2,
      ACT_QUERY      = 2'd3
   } fmpll_action_type;

   // Bus slot codes carried on the slot kind field.
   typedef enum logic [2:0] {
      SLOT_NONE  = 3'd0,
      SLOT_START = 3'd1,
      SLOT_DATA  = 3'd2,
      SLOT_ACK   = 3'd3,
      SLOT_STOP  = 3'd4
   } fmpll_slot_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_FREQ_MIN     = 3'd0,
      CSR_FREQ_MAX     = 3'd1,
      CSR_FREQ_DEFAULT = 3'd2,
      CSR_POWER_MIN    = 3'd3,
      CSR_POWER_MAX    = 3'd4,
      CSR_PLL_ADDR     = 3'd5
   } fmpll_csr_type;

   // Byte positions within the PLL frame.
   typedef enum logic [2:0] {
      BYTE_ADDR     = 3'd0,
      BYTE_FREQ_MSB = 3'd1,
      BYTE_FREQ_LSB = 3'd2,
      BYTE_CONST    = 3'd3,
      BYTE_POWER    = 3'd4
   } fmpll_byte_type;

   localparam logic [7:0] FRAME_CONST = 8'd192;
   // Slot position within a byte that carries the acknowledge.
   localparam logic [3:0] ACK_SLOT    = 4'd8;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic           take_req;   // request accepted this cycle
      logic           load_slot;  // load the result register
      fmpll_slot_type kind;
      logic           last;
      fmpll_byte_type byte_sel;
      logic [2:0]     bit_sel;    // bit index within the byte, 7 first
   } fmpll_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;  // result register can take a new slot this cycle
   } fmpll_sts_type;

   // Lower limit is checked first, then the upper one.
   function automatic logic [15:0] clamp16(input logic [15:0] v,
                                           input logic [15:0] lo,
                                           input logic [15:0] hi);
      logic [15:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== rtl/fmpll_ctrl.sv =====
`timescale 1ns / 1ps

module fmpll_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_action,
   output logic                    req_stall,
   input  fmpll_pkg::fmpll_sts_type sts,
   output fmpll_pkg::fmpll_cmd_type cmd
);
   import fmpll_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STATUS,
      ST_START,
      ST_BITS,
      ST_STOP
   } state_type;

   state_type      state_ff, state_in;
   fmpll_byte_type byte_ff, byte_in;
   logic [3:0]     slot_ff, slot_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      byte_in      = byte_ff;
      slot_in      = slot_ff;
      cmd.take_req  = 1'b0;
      cmd.load_slot = 1'b0;
      cmd.kind      = SLOT_NONE;
      cmd.last      = 1'b0;
      cmd.byte_sel  = byte_ff;
      cmd.bit_sel   = 3'd7 - slot_ff[2:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               if (req_action == ACT_SET_STEREO || req_action == ACT_QUERY) begin
                  state_in = ST_STATUS;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_STATUS: begin
            cmd.kind = SLOT_NONE;
            cmd.last = 1'b1;
            if (sts.out_free) begin
               cmd.load_slot = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_START: begin
            cmd.kind = SLOT_START;
            if (sts.out_free) begin
               cmd.load_slot = 1'b1;
               byte_in       = BYTE_ADDR;
               slot_in       = 4'd0;
               state_in      = ST_BITS;
            end
         end
         ST_BITS: begin
            cmd.kind = (slot_ff == ACK_SLOT) ? SLOT_ACK : SLOT_DATA;
            if (sts.out_free) begin
               cmd.load_slot = 1'b1;
               if (slot_ff == ACK_SLOT) begin
                  slot_in = 4'd0;
                  if (byte_ff == BYTE_POWER) begin
                     state_in = ST_STOP;
                  end else begin
                     byte_in = fmpll_byte_type'(byte_ff + 3'd1);
                  end
               end else begin
                  slot_in = slot_ff + 4'd1;
               end
            end
         end
         ST_STOP: begin
            cmd.kind = SLOT_STOP;
            cmd.last = 1'b1;
            if (sts.out_free) begin
               cmd.load_slot = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         byte_ff  <= BYTE_ADDR;
         slot_ff  <= 4'd0;
      end else begin
         state_ff <= state_in;
         byte_ff  <= byte_in;
         slot_ff  <= slot_in;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_slot |-> sts.out_free)
      else $error("slot loaded while the result register was occupied");

   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.take_req |=> state_ff != ST_IDLE)
      else $error("request taken but the controller stayed idle");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= ACK_SLOT && byte_ff <= BYTE_POWER)
      else $error("frame position counter out of range");

endmodule

// ===== rtl/fmpll_dp.sv =====
`timescale 1ns / 1ps

module fmpll_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               req_action,
   input  logic [15:0]              req_value,
   input  logic                     csr_valid,
   input  logic [2:0]               csr_index,
   input  logic [15:0]              csr_data,
   input  fmpll_pkg::fmpll_cmd_type cmd,
   output fmpll_pkg::fmpll_sts_type sts,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_slot_kind,
   output logic                     rsp_sda_level,
   output logic                     rsp_mono_level,
   output logic [15:0]              rsp_freq_now,
   output logic [7:0]               rsp_power_now,
   output logic                     rsp_programmed,
   output logic                     rsp_last
);
   import fmpll_pkg::*;

   logic [15:0] freq_min_ff, freq_max_ff, freq_default_ff;
   logic [7:0]  power_min_ff, power_max_ff, pll_addr_ff;

   logic [15:0] freq_ff, freq_in;
   logic [7:0]  power_ff, power_in;
   logic        programmed_ff;
   logic        mono_ff;

   logic        valid_ff;
   logic [2:0]  kind_ff;
   logic        sda_ff, mono_out_ff, prog_out_ff, last_ff;
   logic [15:0] freq_out_ff;
   logic [7:0]  power_out_ff;

   logic [15:0] freq_clamped, power_clamped;
   logic [7:0]  frame_byte;
   logic        sda_in;

   // One shared clamp for each quantity: the requested value or the stored one.
   assign freq_clamped = clamp16((req_action == ACT_SET_FREQ) ? req_value : freq_ff,
                                 freq_min_ff, freq_max_ff);
   assign power_clamped = clamp16((req_action == ACT_SET_POWER) ? req_value
                                                                : {8'd0, power_ff},
                                  {8'd0, power_min_ff}, {8'd0, power_max_ff});

   always_comb begin
      if (req_action == ACT_SET_FREQ) begin
         freq_in  = freq_clamped;
         power_in = programmed_ff ? power_clamped[7:0] : power_min_ff;
      end else begin
         freq_in  = programmed_ff ? freq_clamped : freq_default_ff;
         power_in = power_clamped[7:0];
      end
   end

   always_comb begin
      unique case (cmd.byte_sel)
         BYTE_ADDR:     frame_byte = pll_addr_ff;
         BYTE_FREQ_MSB: frame_byte = freq_ff[15:8];
         BYTE_FREQ_LSB: frame_byte = freq_ff[7:0];
         BYTE_CONST:    frame_byte = FRAME_CONST;
         BYTE_POWER:    frame_byte = power_ff;
         default:       frame_byte = FRAME_CONST;
      endcase
   end

   always_comb begin
      unique case (cmd.kind)
         SLOT_START: sda_in = 1'b0;
         SLOT_DATA:  sda_in = frame_byte[cmd.bit_sel];
         default:    sda_in = 1'b1;
      endcase
   end

   assign sts.out_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_min_ff     <= 16'd0;
         freq_max_ff     <= 16'hFFFF;
         freq_default_ff <= 16'd0;
         power_min_ff    <= 8'd0;
         power_max_ff    <= 8'hFF;
         pll_addr_ff     <= 8'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FREQ_MIN:     freq_min_ff     <= csr_data;
            CSR_FREQ_MAX:     freq_max_ff     <= csr_data;
            CSR_FREQ_DEFAULT: freq_default_ff <= csr_data;
            CSR_POWER_MIN:    power_min_ff    <= csr_data[7:0];
            CSR_POWER_MAX:    power_max_ff    <= csr_data[7:0];
            CSR_PLL_ADDR:     pll_addr_ff     <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff       <= 16'd0;
         power_ff      <= 8'd0;
         programmed_ff <= 1'b0;
         mono_ff       <= 1'b0;
      end else if (cmd.take_req) begin
         if (req_action == ACT_SET_STEREO) begin
            mono_ff <= (req_value == 16'd0);
         end else if (req_action == ACT_SET_FREQ || req_action == ACT_SET_POWER) begin
            freq_ff       <= freq_in;
            power_ff      <= power_in;
            programmed_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.load_slot) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_slot) begin
         kind_ff      <= cmd.kind;
         sda_ff       <= sda_in;
         mono_out_ff  <= mono_ff;
         freq_out_ff  <= freq_ff;
         power_out_ff <= power_ff;
         prog_out_ff  <= programmed_ff;
         last_ff      <= cmd.last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_slot_kind  = kind_ff;
   assign rsp_sda_level  = sda_ff;
   assign rsp_mono_level = mono_out_ff;
   assign rsp_freq_now   = freq_out_ff;
   assign rsp_power_now  = power_out_ff;
   assign rsp_programmed = prog_out_ff;
   assign rsp_last       = last_ff;

   a_bus_slot_programmed: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff != SLOT_NONE) |-> prog_out_ff)
      else $error("bus slot emitted before any frame was programmed");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff) |-> (kind_ff == SLOT_NONE || kind_ff == SLOT_STOP))
      else $error("last marker on a slot that cannot end a request");

endmodule

// ===== rtl/fm_pll_i2c_frame_writer.sv =====
`timescale 1ns / 1ps

// FM transmitter PLL frame writer. A set-frequency or set-power request clamps
// the value against the configured limits, stores it and then sends the full
// PLL write frame as 47 bus slot results: a start, the address byte, frequency
// MSB, frequency LSB, the constant 192 and the power byte, each eight data bits
// MSB first plus one released acknowledge slot, and finally a stop. A
// set-stereo or query request gives one status result with no bus slot. Every
// result carries the stored frequency, power, mono and programmed state, and
// the final result of a request has last set. One request is handled at a
// time: a frame request occupies the block while the request is taken and the
// stored state updated and then while each slot is sent, a status request
// while it is taken and its result sent, and both wait out any stall of the
// result channel, since the controller steps through the frame one slot per
// transfer on the result channel. A new request is taken as soon as the last
// slot of the previous one sits in the result register. Configuration writes
// are always ready and should be made only while no request is in flight.
module fm_pll_i2c_frame_writer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_slot_kind,
   output logic        rsp_sda_level,
   output logic        rsp_mono_level,
   output logic [15:0] rsp_freq_now,
   output logic [7:0]  rsp_power_now,
   output logic        rsp_programmed,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import fmpll_pkg::*;

   fmpll_cmd_type cmd;
   fmpll_sts_type sts;

   // The register file never back-pressures a write.
   assign csr_ready = 1'b1;

   fmpll_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   fmpll_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_action     (req_action),
      .req_value      (req_value),
      .csr_valid      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot_kind  (rsp_slot_kind),
      .rsp_sda_level  (rsp_sda_level),
      .rsp_mono_level (rsp_mono_level),
      .rsp_freq_now   (rsp_freq_now),
      .rsp_power_now  (rsp_power_now),
      .rsp_programmed (rsp_programmed),
      .rsp_last       (rsp_last)
   );

endmodule
